[hw/rtl/cesc_pkg.sv]
// Shared types, character codes and decode functions of the escape expander.
package cesc_pkg;

  // Scanner modes
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_OCT  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  // One or two results produced by a single input item
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } res_pair_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Map the letter after a backslash to its control code; others stand for themselves
  function automatic logic [7:0] esc_char(input logic [7:0] b);
    logic [7:0] ch;
    case (b)
      8'h65:   ch = 8'h1B; // e: escape
      8'h61:   ch = 8'h07; // a: bell
      8'h62:   ch = 8'h08; // b: backspace
      8'h66:   ch = 8'h0C; // f: form feed
      8'h6E:   ch = 8'h0A; // n: line feed
      8'h72:   ch = 8'h0D; // r: carriage return
      8'h74:   ch = 8'h09; // t: tab
      8'h76:   ch = 8'h0B; // v: vertical tab
      default: ch = b;
    endcase
    return ch;
  endfunction

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    if (b inside {[CH_ZERO:CH_NINE]}) begin
      r = {1'b1, 4'(b - CH_ZERO)};
    end else if (b inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(b - CH_UA + 8'd10)};
    end else if (b inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(b - CH_LA + 8'd10)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

[hw/rtl/cesc_front.sv]
// Front end: scans input items, tracks escape state and forms result pairs.
module cesc_front import cesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_line_end,
  output logic       push,
  output res_pair_t  push_data
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] accum_r, accum_nxt;
  logic [1:0] count_r, count_nxt;

  logic       is_bslash, is_numlead, is_oct;
  logic       digit_ok;
  logic [3:0] digit_val;
  logic [4:0] hex_dec;
  logic [7:0] acc_new;
  logic [1:0] cnt_inc;
  logic       num_done;
  logic       has_res;

  assign is_oct    = (mode_r == MODE_OCT);
  assign is_bslash = (in_byte == CH_BSLASH);
  assign is_numlead = (in_byte == CH_ZERO) || (in_byte == CH_X);
  assign hex_dec   = hex_digit(in_byte);

  always_comb begin
    if (is_oct) begin
      digit_ok  = in_byte inside {[CH_ZERO:CH_SEVEN]};
      digit_val = {1'b0, in_byte[2:0]};
      acc_new   = {accum_r[4:0], digit_val[2:0]};
    end else begin
      digit_ok  = hex_dec[4];
      digit_val = hex_dec[3:0];
      acc_new   = {accum_r[3:0], digit_val};
    end
  end

  assign cnt_inc  = count_r + 2'd1;
  assign num_done = in_line_end || (cnt_inc == (is_oct ? OCT_DIGITS : HEX_DIGITS));

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    count_nxt = count_r;
    case (mode_r)
      MODE_TEXT: begin
        mode_nxt = (is_bslash && !in_line_end) ? MODE_ESC : MODE_TEXT;
      end
      MODE_ESC: begin
        if (is_numlead) begin
          accum_nxt = 8'd0;
          count_nxt = 2'd0;
          if (in_line_end) begin
            mode_nxt = MODE_TEXT;
          end else begin
            mode_nxt = (in_byte == CH_ZERO) ? MODE_OCT : MODE_HEX;
          end
        end else begin
          mode_nxt = MODE_TEXT;
        end
      end
      MODE_OCT, MODE_HEX: begin
        if (digit_ok) begin
          if (num_done) begin
            mode_nxt  = MODE_TEXT;
            accum_nxt = 8'd0;
            count_nxt = 2'd0;
          end else begin
            accum_nxt = acc_new;
            count_nxt = cnt_inc;
          end
        end else begin
          accum_nxt = 8'd0;
          count_nxt = 2'd0;
          mode_nxt  = (is_bslash && !in_line_end) ? MODE_ESC : MODE_TEXT;
        end
      end
      default: mode_nxt = MODE_TEXT;
    endcase
  end

  // Results
  always_comb begin
    has_res   = 1'b0;
    push_data = '0;
    case (mode_r)
      MODE_TEXT: begin
        if (is_bslash) begin
          has_res         = in_line_end;
          push_data.byte0 = CH_NUL;
          push_data.last0 = 1'b1;
        end else begin
          has_res         = 1'b1;
          push_data.byte0 = in_byte;
          push_data.last0 = in_line_end;
        end
      end
      MODE_ESC: begin
        if (is_numlead) begin
          has_res         = in_line_end;
          push_data.byte0 = CH_NUL;
          push_data.last0 = 1'b1;
        end else begin
          has_res         = 1'b1;
          push_data.byte0 = esc_char(in_byte);
          push_data.last0 = in_line_end;
        end
      end
      MODE_OCT, MODE_HEX: begin
        has_res = 1'b1;
        if (digit_ok) begin
          has_res         = num_done;
          push_data.byte0 = acc_new;
          push_data.last0 = in_line_end;
        end else begin
          // flush the value, then handle the ending byte as text
          push_data.byte0 = accum_r;
          push_data.last0 = 1'b0;
          if (is_bslash) begin
            push_data.two   = in_line_end;
            push_data.byte1 = CH_NUL;
            push_data.last1 = 1'b1;
          end else begin
            push_data.two   = 1'b1;
            push_data.byte1 = in_byte;
            push_data.last1 = in_line_end;
          end
        end
      end
      default: has_res = 1'b0;
    endcase
  end

  assign push = accept && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      accum_r <= 8'd0;
      count_r <= 2'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[hw/rtl/cesc_queue.sv]
// Short queue of result pairs between the front and back ends.
module cesc_queue import cesc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_pair_t push_data,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output res_pair_t pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  res_pair_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hw/rtl/cesc_back.sv]
// Back end: splits result pairs into single items on the output register.
module cesc_back import cesc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  res_pair_t  q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_line
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       sec_valid_r, sec_valid_nxt;
  logic [7:0] sec_byte_r, sec_byte_nxt;
  logic       sec_last_r, sec_last_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = slot_free && !sec_valid_r && q_not_empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    sec_valid_nxt = sec_valid_r;
    sec_byte_nxt  = sec_byte_r;
    sec_last_nxt  = sec_last_r;
    if (slot_free) begin
      if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = sec_byte_r;
        out_last_nxt  = sec_last_r;
        sec_valid_nxt = 1'b0;
      end else if (q_not_empty) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = q_data.byte0;
        out_last_nxt  = q_data.last0;
        sec_valid_nxt = q_data.two;
        sec_byte_nxt  = q_data.byte1;
        sec_last_nxt  = q_data.last1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    sec_byte_r <= sec_byte_nxt;
    sec_last_r <= sec_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_line = out_last_r;

endmodule

[hw/rtl/c_escape_sequence_expander_core.sv]
// Top level of the C escape sequence expander: front end, pair queue, back end.
//
// Usage: feed raw text bytes on the in_ channel (in_byte, in_line_end marks
// the last byte of a line). Expanded bytes leave on the out_ channel with
// out_last_of_line set on the final byte produced for each line. Both
// channels use valid/ready; an item moves when valid and ready are high.
// An input item yields zero, one or two output items; a line end always
// yields at least one, and every line end returns the scanner to plain text.
// An accepted item's result pair is written into the queue, and its first
// result is then loaded from the queue into the output register.
// Throughput: one input item per cycle while the queue has room; the output
// register moves one item per cycle while out_ready is high, so a two-result
// item holds the back end longer, absorbed by the QUEUE_DEPTH-entry pair queue.
// in_ready falls only when the queue is full, so a stalled receiver fills the
// queue and then holds off the sender; no item is lost or repeated.
// Reset (rst_n low, synchronous) clears the scanner to plain text, empties
// the queue and drops any pending output; no clearing pass is needed.
module c_escape_sequence_expander_core import cesc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_line
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             accept;
  logic             q_push, q_pop;
  logic             q_not_full, q_not_empty;
  res_pair_t        q_wdata, q_rdata;
  logic [CNT_W-1:0] q_count;

  // Take an item whenever the queue has room for its result pair
  assign in_ready = q_not_full;
  assign accept   = in_valid && q_not_full;

  cesc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_line_end (in_line_end),
    .push        (q_push),
    .push_data   (q_wdata)
  );

  cesc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata),
    .count     (q_count)
  );

  cesc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_line (out_last_of_line)
  );

  // Every line end must produce a result
  a_line_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_line_end) |-> q_push)
    else $error("line end accepted without a result");

  // The flushed value of a pair never closes the line
  a_pair_first_open: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata.two) |-> !q_wdata.last0)
    else $error("first result of a pair marked as line end");

  // Queue occupancy stays within its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  // Pop only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != '0))
    else $error("pop from empty queue");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the C escape sequence expander core.
module tb_top;
  import cesc_pkg::*;

  // Control codes produced by the letter escapes
  localparam logic [7:0] CC_ESC = 8'h1B;
  localparam logic [7:0] CC_BEL = 8'h07;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_VT  = 8'h0B;
  localparam logic [7:0] CC_HT  = 8'h09;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int ITEMS_PER_PH = 450;
  localparam int DRAIN_CYCLES = 8;

  // One expanded byte as it should leave the block
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_item_t;

  // One row of the directed table. Where typed is set, n results b0/l0, b1/l1
  // are what the block must give; otherwise the predictor decides.
  typedef struct packed {
    logic [7:0] b;
    logic       le;
    logic       typed;
    logic [1:0] n;
    logic [7:0] b0;
    logic       l0;
    logic [7:0] b1;
    logic       l1;
  } dir_row_t;

  localparam int NUM_ROWS = 28;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    // plain text, top byte with line end, zero byte
    '{8'h41,     1'b0, 1'b1, 2'd1, 8'h41,  1'b0, 8'h00, 1'b0},
    '{8'hFF,     1'b1, 1'b1, 2'd1, 8'hFF,  1'b1, 8'h00, 1'b0},
    '{CH_NUL,    1'b0, 1'b1, 2'd1, CH_NUL, 1'b0, 8'h00, 1'b0},
    // backslash on the last byte of a line gives zero
    '{CH_BSLASH, 1'b1, 1'b1, 2'd1, CH_NUL, 1'b1, 8'h00, 1'b0},
    // letter escapes
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{"e",       1'b0, 1'b1, 2'd1, CC_ESC, 1'b0, 8'h00, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{"n",       1'b0, 1'b1, 2'd1, CC_LF,  1'b0, 8'h00, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{"v",       1'b1, 1'b1, 2'd1, CC_VT,  1'b1, 8'h00, 1'b0},
    // '0' right after a backslash on the last byte
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_ZERO,   1'b1, 1'b1, 2'd1, CH_NUL, 1'b1, 8'h00, 1'b0},
    // full octal number, 0777 wraps to 0xFF
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_ZERO,   1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_SEVEN,  1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_SEVEN,  1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_SEVEN,  1'b0, 1'b1, 2'd1, 8'hFF,  1'b0, 8'h00, 1'b0},
    // full hex number, mixed case
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_X,      1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_UF,     1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_LF,     1'b0, 1'b1, 2'd1, 8'hFF,  1'b0, 8'h00, 1'b0},
    // hex digit on the last byte flushes the value
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_X,      1'b0, 1'b1, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{"c",       1'b1, 1'b1, 2'd1, 8'h0C,  1'b1, 8'h00, 1'b0},
    // non-digit ends a number: two results, left to the predictor
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{CH_ZERO,   1'b0, 1'b0, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{"5",       1'b0, 1'b0, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0},
    '{"z",       1'b1, 1'b0, 2'd0, 8'h00,  1'b0, 8'h00, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_line_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_line;

  // Predictor state: scanner mode, number being collected, digits so far
  mode_t      scan_mode;
  logic [7:0] num_acc;
  logic [1:0] num_digits;

  out_item_t  step_out [$];       // results of the byte just expanded
  out_item_t  expected_bytes [$]; // results still owed by the block

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int items_sent;
  int line_ends_sent;
  int results_seen;
  int cycle_count;

  string esc_letters = "eabfnrtv";
  string hex_chars   = "0123456789abcdefABCDEF";

  c_escape_sequence_expander_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_line (out_last_of_line)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop: a hung handshake must not hold the run forever
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, expected_bytes.size());
      $display("** c_escape_sequence_expander_core: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure: drop ready at random in the current idle ratio
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every accepted result with the oldest one owed, field by field
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_bytes.size() == 0) begin
        error_count <= error_count + 1;
        $display("%0t: unexpected result, expected none, actual byte %02h last %0b",
                 $time, out_byte, out_last_of_line);
      end else begin
        exp_item = expected_bytes.pop_front();
        if (out_byte !== exp_item.b) begin
          error_count <= error_count + 1;
          $display("%0t: out_byte mismatch, expected %02h actual %02h",
                   $time, exp_item.b, out_byte);
        end
        if (out_last_of_line !== exp_item.last) begin
          error_count <= error_count + 1;
          $display("%0t: out_last_of_line mismatch, expected %0b actual %0b",
                   $time, exp_item.last, out_last_of_line);
        end
      end
    end
  end

  function automatic void owe(input logic [7:0] b, input logic last);
    out_item_t r;
    r.b    = b;
    r.last = last;
    step_out.push_back(r);
  endfunction

  // A byte taken as ordinary text; a backslash opens an escape unless the
  // line ends on it, in which case it stands for zero.
  function automatic void take_plain(input logic [7:0] b, input logic le);
    if (b == CH_BSLASH) begin
      if (le) begin
        scan_mode = MODE_TEXT;
        owe(CH_NUL, 1'b1);
      end else begin
        scan_mode = MODE_ESC;
      end
    end else begin
      scan_mode = MODE_TEXT;
      owe(b, le);
    end
  endfunction

  // Work out what one input byte should make the block emit, and advance
  // the predictor state to match
  function automatic void expand_step(input logic [7:0] b, input logic le);
    logic       is_digit;
    logic [3:0] dval;
    logic       is_oct;
    int         cnt;
    step_out.delete();
    case (scan_mode)
      MODE_ESC: begin
        if (b == CH_ZERO || b == CH_X) begin
          num_acc    = 8'h00;
          num_digits = 2'd0;
          if (le) begin
            scan_mode = MODE_TEXT;
            owe(CH_NUL, 1'b1);
          end else begin
            scan_mode = (b == CH_ZERO) ? MODE_OCT : MODE_HEX;
          end
        end else begin
          scan_mode = MODE_TEXT;
          case (b)
            "e":     owe(CC_ESC, le);
            "a":     owe(CC_BEL, le);
            "b":     owe(8'h08, le);
            "f":     owe(8'h0C, le);
            "n":     owe(CC_LF, le);
            "r":     owe(8'h0D, le);
            "t":     owe(CC_HT, le);
            "v":     owe(CC_VT, le);
            default: owe(b, le);
          endcase
        end
      end
      MODE_OCT, MODE_HEX: begin
        is_oct = (scan_mode == MODE_OCT);
        is_digit = 1'b1;
        if (is_oct && b >= CH_ZERO && b <= CH_SEVEN) begin
          dval = 4'(b - CH_ZERO);
        end else if (!is_oct && b >= CH_ZERO && b <= CH_NINE) begin
          dval = 4'(b - CH_ZERO);
        end else if (!is_oct && b >= CH_UA && b <= CH_UF) begin
          dval = 4'(b - CH_UA + 8'd10);
        end else if (!is_oct && b >= CH_LA && b <= CH_LF) begin
          dval = 4'(b - CH_LA + 8'd10);
        end else begin
          is_digit = 1'b0;
          dval = 4'd0;
        end
        if (is_digit) begin
          cnt = int'(num_digits) + 1;
          // shift in the digit, keeping only the low 8 bits
          num_acc = is_oct ? {num_acc[4:0], dval[2:0]} : {num_acc[3:0], dval};
          if (le || cnt >= int'(is_oct ? OCT_DIGITS : HEX_DIGITS)) begin
            owe(num_acc, le);
            scan_mode  = MODE_TEXT;
            num_acc    = 8'h00;
            num_digits = 2'd0;
          end else begin
            num_digits = 2'(cnt);
          end
        end else begin
          // flush the number, then treat the terminator as ordinary text
          owe(num_acc, 1'b0);
          num_acc    = 8'h00;
          num_digits = 2'd0;
          take_plain(b, le);
        end
      end
      default: take_plain(b, le);
    endcase
  endfunction

  // Present one item, idling first at the current sender ratio, and hold it
  // until the block takes it
  task automatic send_item(input logic [7:0] b, input logic le);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    in_line_end <= le;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (le) line_ends_sent++;
  endtask

  // Send a byte and owe whatever the predictor says it gives
  task automatic feed(input logic [7:0] b, input logic le);
    send_item(b, le);
    expand_step(b, le);
    foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
  endtask

  function automatic logic rand_line_end();
    return ($urandom_range(0, 11) == 0);
  endfunction

  // Mostly well-formed escapes with random content; a line end may cut
  // any of them short, and a share of raw noise bytes is mixed in
  task automatic feed_random(input int target);
    int kind;
    int ndig;
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        feed(8'($urandom_range(32, 126)), rand_line_end());
      end else if (kind < 40) begin
        feed(CH_BSLASH, rand_line_end());
        if ($urandom_range(0, 4) != 0)
          feed(esc_letters[$urandom_range(0, esc_letters.len() - 1)], rand_line_end());
        else
          feed(8'($urandom_range(0, 255)), rand_line_end());
      end else if (kind < 62) begin
        feed(CH_BSLASH, rand_line_end());
        feed(CH_ZERO, rand_line_end());
        ndig = $urandom_range(0, 4);
        repeat (ndig) feed(CH_ZERO + 8'($urandom_range(0, 7)), rand_line_end());
        if ($urandom_range(0, 1) != 0)
          feed(8'($urandom_range(CH_SEVEN + 1, 8'h7E)), rand_line_end());
      end else if (kind < 84) begin
        feed(CH_BSLASH, rand_line_end());
        feed(CH_X, rand_line_end());
        ndig = $urandom_range(0, 3);
        repeat (ndig) feed(hex_chars[$urandom_range(0, hex_chars.len() - 1)],
                           rand_line_end());
      end else begin
        feed(8'($urandom_range(0, 255)), $urandom_range(0, 1) != 0);
      end
    end
  endtask

  initial begin
    logic [7:0] row_b;
    scan_mode      = MODE_TEXT;
    num_acc        = 8'h00;
    num_digits     = 2'd0;
    send_idle_pct  = 30;
    recv_idle_pct  = 74;
    error_count    = 0;
    items_sent     = 0;
    line_ends_sent = 0;
    results_seen   = 0;
    cycle_count    = 0;

    // Hold reset, then release it once and for all
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed rows owe their listed results, the rest
    // owe what the predictor works out
    for (int i = 0; i < NUM_ROWS; i++) begin
      row_b = DIRECTED[i].b;
      send_item(row_b, DIRECTED[i].le);
      expand_step(row_b, DIRECTED[i].le);
      if (DIRECTED[i].typed) begin
        if (DIRECTED[i].n >= 2'd1)
          expected_bytes.push_back('{DIRECTED[i].b0, DIRECTED[i].l0});
        if (DIRECTED[i].n >= 2'd2)
          expected_bytes.push_back('{DIRECTED[i].b1, DIRECTED[i].l1});
      end else begin
        foreach (step_out[i2]) expected_bytes.push_back(step_out[i2]);
      end
    end

    // Random phases: sender light/receiver heavy, swapped, then flat out
    feed_random(ITEMS_PER_PH);
    send_idle_pct = 74;
    recv_idle_pct = 30;
    feed_random(ITEMS_PER_PH);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    feed_random(ITEMS_PER_PH);
    in_valid <= 1'b0;

    // Drain, then keep the clock running so the pipeline can show strays
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d line ends) through letter, octal and hex escapes",
             items_sent, line_ends_sent);
    $display("checked %0d expanded bytes under three stall mixes, %0d errors",
             results_seen, error_count);
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("** c_escape_sequence_expander_core: PASSED **");
    end else begin
      $display("** c_escape_sequence_expander_core: FAILED **");
    end
    $finish;
  end

endmodule
